// ----- design/slrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slrs_pkg
// Shared types, codes and helper functions of the status LED request stack.
// ----------------------------------------------------------------------------
package slrs_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 4;

  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_LOW  = 2'd2;
  localparam logic [1:0] MODE_HIGH = 2'd3;

  localparam logic [7:0] FAST_TICKS_RESET = 8'd2;
  localparam logic [7:0] SLOW_TICKS_RESET = 8'd6;

  localparam logic SHOW_PRESS = 1'b0;
  localparam logic SHOW_ENTRY = 1'b1;

  typedef struct packed {
    logic [7:0]  layer;
    logic [7:0]  position;
    logic [7:0]  source;
    logic [31:0] event_time;
    logic [5:0]  modes;
  } req_entry_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] countdown;
    logic       armed;
  } blink_t;

  function automatic blink_t blink_eval(input logic [5:0] modes, input logic [1:0] phase,
                                        input logic [7:0] fast_ticks,
                                        input logic [7:0] slow_ticks);
    logic   any_high;
    logic   any_low;
    blink_t res;
    any_high = (modes[1:0] == MODE_HIGH) || (modes[3:2] == MODE_HIGH) ||
               (modes[5:4] == MODE_HIGH);
    any_low  = (modes[1:0] == MODE_LOW) || (modes[3:2] == MODE_LOW) ||
               (modes[5:4] == MODE_LOW);
    if (any_high) begin
      res.phase     = phase + 2'd1;
      res.countdown = fast_ticks;
      res.armed     = 1'b1;
    end else if (any_low) begin
      res.phase     = phase + 2'd2;
      res.countdown = slow_ticks;
      res.armed     = 1'b1;
    end else begin
      res.phase     = 2'd0;
      res.countdown = 8'd0;
      res.armed     = 1'b0;
    end
    return res;
  endfunction

  function automatic logic pin_level(input logic [1:0] mode, input logic [1:0] phase);
    return (mode == MODE_FULL) || ((mode == MODE_HIGH) && phase[0]) ||
           ((mode == MODE_LOW) && phase[1]);
  endfunction

endpackage
`default_nettype wire

// ----- design/status_led_request_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_led_request_stack
// Drives three status LEDs from a small table of active key requests.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. The command
// is a press, a release or a 100 ms tick. Exactly one result transaction
// follows, shown for one cycle with done high: the three LED pin levels and
// the number of requests held. The receiver cannot stall; the result must be
// taken in that cycle.
// A press into a table that is not full goes through the write and show
// steps; a tick or an unused command goes straight to the result. A press
// into a full table first scans every entry for the oldest timestamp, one
// entry a cycle. A release scans the held entries one a cycle; with at most
// one entry it skips the scan and goes straight to the show step. The scan
// goes through the single table read port. busy stays high from acceptance
// until the result cycle is over.
// The blink timing registers are written over the APB port, fast ticks at
// address 0, slow ticks at 4; the user must write them only while the block
// is idle, which it does not enforce. Reset empties the table, shows all
// LEDs off, stops the blink timer and loads the timing registers with 2 and 6.
// ----------------------------------------------------------------------------
module status_led_request_stack #(
  parameter int TABLE_DEPTH = slrs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  key_layer,
  input  wire logic [7:0]  key_position,
  input  wire logic [7:0]  key_source,
  input  wire logic [31:0] event_time,
  input  wire logic [1:0]  led0_mode,
  input  wire logic [1:0]  led1_mode,
  input  wire logic [1:0]  led2_mode,
  output logic             done,
  output logic             led0_on,
  output logic             led1_on,
  output logic             led2_on,
  output logic [2:0]       active_requests
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MOVE   = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_SHOW   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [5:0]           shown_modes;
  logic [5:0]           shown_modes_next;
  logic [1:0]           phase;
  logic [7:0]           countdown;
  logic                 armed;
  slrs_pkg::blink_t     blink_next;
  logic [7:0]           fast_ticks;
  logic [7:0]           slow_ticks;

  slrs_pkg::req_entry_t entries [TABLE_DEPTH];
  slrs_pkg::req_entry_t req;
  logic                 op_press;
  logic [IDX_W-1:0]     idx;
  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  logic                 max_valid;
  logic [IDX_W-1:0]     max_idx;
  logic [31:0]          max_t;
  logic                 fb_valid;
  logic [IDX_W-1:0]     fb_idx;
  logic [IDX_W-1:0]     min_idx;
  logic [31:0]          min_t;
  logic                 show_sel;
  logic [IDX_W-1:0]     show_idx;

  logic [IDX_W-1:0]     rd_idx;
  slrs_pkg::req_entry_t rd_entry;
  logic [IDX_W-1:0]     last_idx;
  logic [CNT_W-1:0]     scan_end;
  logic                 scan_last;
  logic                 is_match;
  logic                 is_newer;
  logic                 accept;
  logic                 cfg_write;
  logic                 blink_load;
  logic [5:0]           show_modes;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? {24'd0, slow_ticks} : {24'd0, fast_ticks};

  assign last_idx  = IDX_W'(count - CNT_W'(1));
  assign scan_end  = op_press ? CNT_W'(TABLE_DEPTH) : count;
  assign scan_last = (CNT_W'(idx) == (scan_end - CNT_W'(1)));

  always_comb begin
    unique case (state)
      S_SCAN:  rd_idx = idx;
      S_MOVE:  rd_idx = last_idx;
      default: rd_idx = show_idx;
    endcase
  end

  assign rd_entry = entries[rd_idx];
  assign is_match = (rd_entry.layer == req.layer) && (rd_entry.position == req.position) &&
                    (rd_entry.source == req.source);
  assign is_newer = !max_valid || (rd_entry.event_time > max_t);

  always_comb begin
    priority if (show_sel == slrs_pkg::SHOW_PRESS) begin
      show_modes = req.modes;
    end else if (max_valid) begin
      show_modes = rd_entry.modes;
    end else begin
      show_modes = 6'd0;
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    shown_modes_next = shown_modes;
    blink_load       = 1'b0;
    blink_next       = slrs_pkg::blink_eval(shown_modes, phase, fast_ticks, slow_ticks);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RESULT;
          if (cmd == slrs_pkg::CMD_PRESS) begin
            state_next = (count >= CNT_W'(TABLE_DEPTH)) ? S_SCAN : S_WRITE;
          end else if (cmd == slrs_pkg::CMD_RELEASE) begin
            state_next = (count <= CNT_W'(1)) ? S_SHOW : S_SCAN;
            if (count <= CNT_W'(1)) begin
              count_next = '0;
            end
          end else if (cmd == slrs_pkg::CMD_TICK && armed) begin
            if (countdown <= 8'd1) begin
              blink_load = 1'b1;
            end else begin
              blink_next.phase     = phase;
              blink_next.countdown = countdown - 8'd1;
              blink_next.armed     = armed;
              blink_load           = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        if (op_press) begin
          count_next = count - CNT_W'(1);
          state_next = S_WRITE;
        end else if (!max_valid) begin
          count_next = '0;
          state_next = S_SHOW;
        end else begin
          count_next = count - CNT_W'(1);
          state_next = S_SHOW;
        end
      end
      S_WRITE: begin
        count_next = count + CNT_W'(1);
        state_next = S_SHOW;
      end
      S_SHOW: begin
        shown_modes_next = show_modes;
        blink_next       = slrs_pkg::blink_eval(show_modes, phase, fast_ticks, slow_ticks);
        blink_load       = 1'b1;
        state_next       = S_RESULT;
      end
      S_RESULT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      shown_modes <= 6'd0;
      phase       <= 2'd0;
      countdown   <= 8'd0;
      armed       <= 1'b0;
      fast_ticks  <= slrs_pkg::FAST_TICKS_RESET;
      slow_ticks  <= slrs_pkg::SLOW_TICKS_RESET;
    end else begin
      state       <= state_next;
      count       <= count_next;
      shown_modes <= shown_modes_next;
      if (blink_load) begin
        phase     <= blink_next.phase;
        countdown <= blink_next.countdown;
        armed     <= blink_next.armed;
      end
      if (cfg_write) begin
        if (paddr[2]) begin
          slow_ticks <= pwdata[7:0];
        end else begin
          fast_ticks <= pwdata[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          req.layer      <= key_layer;
          req.position   <= key_position;
          req.source     <= key_source;
          req.event_time <= event_time;
          req.modes      <= {led2_mode, led1_mode, led0_mode};
          op_press       <= (cmd == slrs_pkg::CMD_PRESS);
          idx            <= '0;
          found          <= 1'b0;
          max_valid      <= 1'b0;
          fb_valid       <= 1'b0;
          show_sel       <= (cmd == slrs_pkg::CMD_PRESS) ? slrs_pkg::SHOW_PRESS
                                                         : slrs_pkg::SHOW_ENTRY;
        end
      end
      S_SCAN: begin
        idx <= idx + IDX_W'(1);
        if (op_press) begin
          if ((idx == '0) || (rd_entry.event_time < min_t)) begin
            min_t   <= rd_entry.event_time;
            min_idx <= idx;
          end
        end else if (is_match) begin
          found     <= 1'b1;
          found_idx <= idx;
        end else if (is_newer) begin
          if (!found) begin
            fb_valid <= max_valid;
            fb_idx   <= max_idx;
          end
          max_valid <= 1'b1;
          max_idx   <= idx;
          max_t     <= rd_entry.event_time;
        end
      end
      S_MOVE: begin
        if (op_press) begin
          entries[min_idx] <= rd_entry;
        end else if (max_valid) begin
          entries[found ? found_idx : max_idx] <= rd_entry;
          show_idx  <= found ? max_idx : fb_idx;
          max_valid <= found || fb_valid;
        end
      end
      S_WRITE: begin
        entries[IDX_W'(count)] <= req;
      end
      default: begin
      end
    endcase
  end

  assign done            = (state == S_RESULT);
  assign led0_on         = slrs_pkg::pin_level(shown_modes[1:0], phase);
  assign led1_on         = slrs_pkg::pin_level(shown_modes[3:2], phase);
  assign led2_on         = slrs_pkg::pin_level(shown_modes[5:4], phase);
  assign active_requests = 3'(count);

endmodule
`default_nettype wire
